// ===== hw/rtl/sld_pkg.sv =====
package sld_pkg;

   // Start word, sent least significant byte first on the link.
   localparam logic [31:0] START_WORD = 32'h0123_4567;

   // Reset value of the receive buffer size register.
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

   // Default width at which the frame size saturates.
   localparam int DEF_LENGTH_BITS = 16;

   localparam logic [1:0] SYNC_LAST   = 2'd3;
   localparam logic [2:0] HEADER_LAST = 3'd7;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_DATA   = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_REJECT = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
      logic        last_byte;
   } result_type;

   // Expected sync byte after the given number of matched bytes.
   function automatic logic [7:0] sync_byte(input logic [1:0] matched);
      logic [31:0] shifted;
      shifted = START_WORD >> {matched, 3'b000};
      return shifted[7:0];
   endfunction

endpackage

// ===== hw/rtl/sld_in_stage.sv =====
module sld_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_stream_byte,
   input  logic       advance,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // The stage holds its beat until the frame logic takes it.
   assign req_stall  = valid_ff && !advance;
   assign valid_in   = req_stall ? valid_ff : req_valid;
   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         byte_ff <= req_stream_byte;
      end
   end

endmodule

// ===== hw/rtl/sld_frame_fsm.sv =====
module sld_frame_fsm #(
   parameter int LENGTH_BITS = sld_pkg::DEF_LENGTH_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          stream_byte,
   input  logic [15:0]         max_payload,
   output logic                res_valid,
   output sld_pkg::result_type result
);

   import sld_pkg::*;

   localparam logic [32:0] SIZE_CAP_WIDE = (33'd1 << LENGTH_BITS) - 33'd1;
   localparam logic [31:0] SIZE_CAP      = SIZE_CAP_WIDE[31:0];

   phase_type   phase_ff, phase_in;
   logic [1:0]  sync_matched_ff, sync_matched_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [63:0] header_shift_ff, header_shift_in;
   logic [15:0] payload_count_ff, payload_count_in;
   logic [15:0] clipped_length_ff, clipped_length_in;

   logic [31:0] size_word;
   logic [31:0] sum_word;
   logic [31:0] total;
   logic [31:0] size_sat;
   logic [31:0] size_clip;
   logic [16:0] idx_plus;
   logic        is_last;

   // Header view including the byte now arriving.
   assign header_shift_in = {stream_byte, header_shift_ff[63:8]};
   assign size_word       = header_shift_in[31:0];
   assign sum_word        = header_shift_in[63:32];
   assign total           = START_WORD + size_word + sum_word;
   assign size_sat        = (size_word > SIZE_CAP) ? SIZE_CAP : size_word;
   assign size_clip       = (size_sat < {16'd0, max_payload}) ? size_sat
                                                             : {16'd0, max_payload};
   assign idx_plus        = {1'b0, payload_count_ff} + 17'd1;
   assign is_last         = idx_plus >= {1'b0, clipped_length_ff};

   always_comb begin
      phase_in          = phase_ff;
      sync_matched_in   = sync_matched_ff;
      header_count_in   = header_count_ff;
      payload_count_in  = payload_count_ff;
      clipped_length_in = clipped_length_ff;
      res_valid         = 1'b0;
      result            = '0;
      result.status     = ST_DATA;

      unique case (phase_ff)
         PH_HEADER: begin
            header_count_in = header_count_ff + 3'd1;
            if (header_count_ff == HEADER_LAST) begin
               payload_count_in = '0;
               if (total != 32'd0) begin
                  phase_in      = PH_HUNT;
                  res_valid     = 1'b1;
                  result.status = ST_REJECT;
               end else begin
                  clipped_length_in = size_clip[15:0];
                  if (size_clip[15:0] == 16'd0) begin
                     phase_in         = PH_HUNT;
                     res_valid        = 1'b1;
                     result.status    = ST_EMPTY;
                     result.last_byte = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            res_valid           = 1'b1;
            result.status       = ST_DATA;
            result.payload_byte = stream_byte;
            result.byte_index   = payload_count_ff;
            result.frame_length = clipped_length_ff;
            result.last_byte    = is_last;
            if (is_last) begin
               phase_in         = PH_HUNT;
               payload_count_in = '0;
            end else begin
               payload_count_in = idx_plus[15:0];
            end
         end
         default: begin
            // Hunting; the spare phase code behaves the same way.
            phase_in = PH_HUNT;
            if (stream_byte == sync_byte(sync_matched_ff)) begin
               if (sync_matched_ff == SYNC_LAST) begin
                  sync_matched_in = '0;
                  header_count_in = '0;
                  phase_in        = PH_HEADER;
               end else begin
                  sync_matched_in = sync_matched_ff + 2'd1;
               end
            end else begin
               sync_matched_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         sync_matched_ff   <= '0;
         header_count_ff   <= '0;
         payload_count_ff  <= '0;
         clipped_length_ff <= '0;
      end else if (step_en) begin
         phase_ff          <= phase_in;
         sync_matched_ff   <= sync_matched_in;
         header_count_ff   <= header_count_in;
         payload_count_ff  <= payload_count_in;
         clipped_length_ff <= clipped_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         header_shift_ff <= header_shift_in;
      end
   end

endmodule

// ===== hw/rtl/sync_length_checksum_deframer.sv =====
// Byte stream deframer: hunts for the little-endian start word 0x01234567,
// gathers an eight-byte header (32-bit size, then 32-bit checksum) and, when
// start plus size plus checksum is zero modulo 2^32, passes on the payload.
// Input channel (req_): one link byte per beat, req_valid / req_stall.
// Result channel (rsp_): at most one result beat per input beat, carrying a
// payload byte with its index, frame length and last flag, an empty-frame
// or a header-reject status; sync and non-final header bytes give none.
// Configuration (csr_): the receive buffer size, which clips the payload
// length; write it only while no beat is in flight.
// A byte accepted from the link is captured in the input register, and its
// result goes through the frame step into the output register.
// Throughput is one byte per cycle while the output register is not held,
// set by the combinational frame step between the input and output registers.
// Reset brings the hunt back to the start and the buffer size to 1024.
// While the receiver stalls, the result is held; the block still accepts a
// byte into its input register and keeps taking sync and header bytes, and
// it stalls the sender only when a second result would have nowhere to go.
module sync_length_checksum_deframer #(
   parameter int LENGTH_BITS = sld_pkg::DEF_LENGTH_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_byte_index,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_last_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_payload
);

   import sld_pkg::*;

   logic        item_valid;
   logic [7:0]  item_byte;
   logic        advance;
   logic        out_free;
   logic        res_valid;
   result_type  result;

   logic [15:0] max_payload_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;

   // The buffer size register takes a write in any cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_valid && csr_ready) begin
         max_payload_ff <= csr_max_payload;
      end
   end

   // The output register is free when empty or when its beat leaves now.
   // A byte that makes no result moves on even while the output is held.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = item_valid && (!res_valid || out_free);

   sld_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .advance         (advance),
      .item_valid      (item_valid),
      .item_byte       (item_byte)
   );

   sld_frame_fsm #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_frame_fsm (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .stream_byte (item_byte),
      .max_payload (max_payload_ff),
      .res_valid   (res_valid),
      .result      (result)
   );

   // Output register: loaded by a result, emptied when the beat is taken.
   always_comb begin
      if (advance && res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_payload_byte = rsp_data_ff.payload_byte;
   assign rsp_byte_index   = rsp_data_ff.byte_index;
   assign rsp_frame_length = rsp_data_ff.frame_length;
   assign rsp_last_byte    = rsp_data_ff.last_byte;

   // The sender is held back only behind a full, stalled output register.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output register could take a beat");

   // Payload bytes always lie inside the clipped frame length.
   a_index_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DATA) |-> (rsp_byte_index < rsp_frame_length))
      else $error("payload byte index beyond frame length");

   // A rejected header carries no length and does not end a frame.
   a_reject_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_REJECT) |->
         (!rsp_last_byte && rsp_frame_length == 16'd0 && rsp_byte_index == 16'd0))
      else $error("reject status with frame fields set");

   // An empty frame is a complete frame of length zero.
   a_empty_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |->
         (rsp_last_byte && rsp_frame_length == 16'd0))
      else $error("empty frame status with wrong fields");

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import sld_pkg::*;

   // Largest frame size that survives saturation, at the default size width.
   localparam logic [31:0] SIZE_CAP = (32'd1 << DEF_LENGTH_BITS) - 32'd1;

   // Cycles to let pass after the last expected result before the block counts
   // as idle: sync bytes and non-final header bytes give no result beat, so
   // the spare cycles cover any byte still inside it.
   localparam int SETTLE_CYCLES = 6;

   // Bound on waiting for outstanding results. It must cover the long hold-off.
   localparam int DRAIN_LIMIT = 5000;

   // Length of the one long receiver hold-off, in cycles.
   localparam int LONG_HOLD = 300;

   // Watchdog.
   localparam int CYCLE_LIMIT = 400000;

   // Scoreboard: tracks the deframer's state from the link bytes that the block
   // accepts, queues the result beat that each byte should cause and checks the
   // beats that come out against that queue, oldest first.
   class deframe_scoreboard;
      logic [15:0] buf_limit;
      phase_type   frame_phase;
      logic [1:0]  sync_seen;
      logic [2:0]  hdr_count;
      logic [63:0] hdr_bits;
      logic [15:0] pay_count;
      logic [15:0] pay_length;
      result_type  awaited[$];
      int          errors;
      int          bytes_taken;
      int          data_beats;
      int          empty_beats;
      int          reject_beats;

      function new();
         buf_limit    = MAX_PAYLOAD_RESET;
         frame_phase  = PH_HUNT;
         sync_seen    = '0;
         hdr_count    = '0;
         hdr_bits     = '0;
         pay_count    = '0;
         pay_length   = '0;
         errors       = 0;
         bytes_taken  = 0;
         data_beats   = 0;
         empty_beats  = 0;
         reject_beats = 0;
      endfunction

      function void set_limit(logic [15:0] value);
         buf_limit = value;
      endfunction

      // True once the hunt is back at the first sync byte.
      function bit hunting();
         return frame_phase == PH_HUNT && sync_seen == 2'd0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Payload length of a frame: size saturated first, then clipped to the
      // receive buffer.
      function logic [15:0] clip_length(logic [31:0] frame_size);
         logic [31:0] held;
         held = (frame_size > SIZE_CAP) ? SIZE_CAP : frame_size;
         return (held < {16'd0, buf_limit}) ? held[15:0] : buf_limit;
      endfunction

      function void take_byte(logic [7:0] link_byte);
         result_type  beat;
         logic [31:0] frame_size;
         logic [31:0] check_word;
         bytes_taken++;
         beat = '0;
         case (frame_phase)
            PH_HEADER: begin
               hdr_bits  = {link_byte, hdr_bits[63:8]};
               hdr_count = hdr_count + 3'd1;
               if (hdr_count == 3'd0) begin
                  frame_size = hdr_bits[31:0];
                  check_word = hdr_bits[63:32];
                  hdr_bits   = '0;
                  if (START_WORD + frame_size + check_word != 32'd0) begin
                     frame_phase = PH_HUNT;
                     beat.status = ST_REJECT;
                     awaited.push_back(beat);
                  end else begin
                     pay_length = clip_length(frame_size);
                     pay_count  = '0;
                     if (pay_length == 16'd0) begin
                        frame_phase    = PH_HUNT;
                        beat.status    = ST_EMPTY;
                        beat.last_byte = 1'b1;
                        awaited.push_back(beat);
                     end else begin
                        frame_phase = PH_PAYLOAD;
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               beat.status       = ST_DATA;
               beat.payload_byte = link_byte;
               beat.byte_index   = pay_count;
               beat.frame_length = pay_length;
               beat.last_byte    = ({1'b0, pay_count} + 17'd1 >= {1'b0, pay_length});
               awaited.push_back(beat);
               pay_count = pay_count + 16'd1;
               if (beat.last_byte) begin
                  frame_phase = PH_HUNT;
                  pay_count   = '0;
               end
            end
            default: begin
               // A byte that breaks the sync run is not tried again as the
               // first sync byte.
               frame_phase = PH_HUNT;
               if (link_byte == START_WORD[8*sync_seen +: 8]) begin
                  if (sync_seen == SYNC_LAST) begin
                     sync_seen   = '0;
                     hdr_count   = '0;
                     hdr_bits    = '0;
                     frame_phase = PH_HEADER;
                  end else begin
                     sync_seen = sync_seen + 2'd1;
                  end
               end else begin
                  sync_seen = '0;
               end
            end
         endcase
      endfunction

      function void match_field(string field, int unsigned want, int unsigned seen);
         if (want != seen) begin
            errors++;
            if (errors < 40)
               $display("%0t: %s expected %0h actual %0h", $time, field, want, seen);
         end
      endfunction

      function void check_result(result_type seen);
         result_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors < 40)
               $display("%0t: unexpected beat, expected none, actual status %0d byte %0h",
                        $time, seen.status, seen.payload_byte);
            return;
         end
         want = awaited.pop_front();
         match_field("status", want.status, seen.status);
         match_field("payload_byte", want.payload_byte, seen.payload_byte);
         match_field("byte_index", want.byte_index, seen.byte_index);
         match_field("frame_length", want.frame_length, seen.frame_length);
         match_field("last_byte", want.last_byte, seen.last_byte);
         case (want.status)
            ST_DATA:  data_beats++;
            ST_EMPTY: empty_beats++;
            default:  reject_beats++;
         endcase
      endfunction

      function void drop_awaited();
         errors++;
         $display("%0t: %0d expected beats never arrived, expected 0 outstanding, actual %0d",
                  $time, awaited.size(), awaited.size());
         awaited.delete();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_byte_index;
   logic [15:0] rsp_frame_length;
   logic        rsp_last_byte;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_max_payload = 16'h0000;

   deframe_scoreboard sb;

   // When clear, both the sender and the receiver run flat out, but for a requested hold-off.
   bit idling = 1'b1;
   // Set by the stimulus to ask the receiver for its long hold-off.
   bit hold_request = 1'b0;
   int cycles = 0;
   logic [15:0] middle_limit;

   sync_length_checksum_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last_byte    (rsp_last_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_payload  (csr_max_payload)
   );

   always #5 clock = ~clock;

   // The watchdog counts every cycle; a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Length of an idle gap: usually none or a few cycles, now and then a long
   // one. Both the sender and the receiver draw from this.
   function automatic int pick_gap();
      int roll;
      if (!idling)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver. It stalls the result channel in random stretches and, once on
   // request, holds off for a long stretch that it counts itself, so that the
   // block fills up and pushes back on the sender.
   initial begin : receiver_pacer
      int span;
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            span = pick_gap();
            if (span > 0) begin
               rsp_stall <= 1'b1;
               repeat (span) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   // Result monitor. Outputs are read at the rising edge, before any of that
   // edge's updates, so a beat counts exactly when valid is high and stall low.
   always @(posedge clock) begin : result_monitor
      result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.status       = status_type'(rsp_status);
         seen.payload_byte = rsp_payload_byte;
         seen.byte_index   = rsp_byte_index;
         seen.frame_length = rsp_frame_length;
         seen.last_byte    = rsp_last_byte;
         sb.check_result(seen);
      end
   end

   // Offers one link byte and returns at the edge where the block takes it.
   // The byte is handed to the scoreboard at that edge. Valid is only lowered
   // when a gap follows, so back-to-back beats keep it high throughout.
   task automatic push_byte(input logic [7:0] link_byte);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= link_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_byte(link_byte);
   endtask

   // Sync word and header. A bad header has one checksum bit flipped.
   task automatic send_header(input logic [31:0] frame_size, input bit sound);
      logic [31:0] check_word;
      check_word = 32'd0 - START_WORD - frame_size;
      if (!sound)
         check_word = check_word ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) push_byte(START_WORD[8*i +: 8]);
      for (int i = 0; i < 4; i++) push_byte(frame_size[8*i +: 8]);
      for (int i = 0; i < 4; i++) push_byte(check_word[8*i +: 8]);
   endtask

   task automatic send_body(input int count);
      repeat (count) push_byte(8'($urandom));
   endtask

   // Stray byte on the link, often one of the sync bytes to start false hunts.
   function automatic logic [7:0] noise_byte();
      int pos;
      pos = $urandom_range(0, 3);
      if ($urandom_range(0, 1) == 1)
         return START_WORD[8*pos +: 8];
      return 8'($urandom);
   endfunction

   // Mostly well-formed frames with random sizes and contents. The rest are
   // bad checksums, oversized frames (only while the buffer is small, so the
   // clipped payload stays short), stray bytes and frames cut off early.
   // Only bytes of complete frames count against the budget.
   task automatic random_traffic(input int budget);
      int          sent;
      int          roll;
      int          count;
      bit          sound;
      logic [31:0] frame_size;
      sent = 0;
      while (sent < budget) begin
         roll = $urandom_range(0, 99);
         if (roll < 78) begin
            sound      = (roll < 60 || roll >= 70);
            frame_size = $urandom_range(0, 12);
            if (roll >= 70 && sb.buf_limit <= 16'd64) begin
               frame_size     = $urandom;
               frame_size[16] = 1'b1;
            end
            send_header(frame_size, sound);
            count = sound ? int'(sb.clip_length(frame_size)) : 0;
            send_body(count);
            sent += 12 + count;
         end else if (roll < 88) begin
            repeat ($urandom_range(1, 6)) push_byte(noise_byte());
         end else begin
            // A partial sync word, or a full one with a partial header, so the
            // next frame's bytes land in the wrong place.
            count = $urandom_range(1, 10);
            for (int i = 0; i < count; i++)
               push_byte(i < 4 ? START_WORD[8*i +: 8] : 8'($urandom));
         end
      end
   endtask

   // Waits for every expected beat, then lets the block's latency pass.
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (sb.pending() != 0)
         sb.drop_awaited();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Brings the block back to the start of the hunt (finishing any frame or
   // sync run that random traffic left open) and lets it go idle, ready for a
   // register write.
   task automatic settle();
      while (!sb.hunting()) push_byte(8'h00);
      drain();
   endtask

   task automatic write_limit(input logic [15:0] value);
      csr_valid       <= 1'b1;
      csr_max_payload <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_limit(value);
   endtask

   initial begin : stimulus
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset buffer size. First a sync run broken by a
      // repeated first byte: the byte that breaks it is not retried, so the
      // rest of the word is lost. Then a header with a bad checksum, and a
      // two-byte frame carrying the extreme byte values.
      push_byte(8'h67);
      push_byte(8'h67);
      push_byte(8'h45);
      push_byte(8'h23);
      push_byte(8'h01);
      send_header(32'd5, 1'b0);
      send_header(32'd2, 1'b1);
      push_byte(8'h00);
      push_byte(8'hff);
      random_traffic(40);

      // A zero buffer turns every good header into an empty-frame beat.
      settle();
      write_limit(16'd0);
      random_traffic(20);

      // One-byte buffer, with neither side idling.
      settle();
      write_limit(16'd1);
      idling = 1'b0;
      random_traffic(30);
      idling = 1'b1;

      // Full-size buffer. The receiver then holds off for a long stretch while
      // the sender keeps offering a long frame, so the block fills and stalls
      // its input; the sender then waits until every beat has come out.
      settle();
      write_limit(16'hffff);
      random_traffic(30);
      settle();
      idling = 1'b0;
      hold_request = 1'b1;
      send_header(32'd100, 1'b1);
      send_body(100);
      idling = 1'b1;
      settle();

      // Small buffer: sizes beyond the saturation point, including one that a
      // plain truncation to 16 bits would turn into zero, clip to the buffer.
      middle_limit = 16'($urandom_range(2, 40));
      write_limit(middle_limit);
      send_header(32'h0001_0000, 1'b1);
      send_body(middle_limit);
      send_header(32'hffff_ffff, 1'b1);
      send_body(middle_limit);
      random_traffic(50);

      drain();
      $display("Covered %0d link bytes giving %0d payload beats,", sb.bytes_taken,
               sb.data_beats);
      $display("%0d empty frames and %0d rejected headers.", sb.empty_beats,
               sb.reject_beats);
      $display("Buffer sizes 1024, 0, 1, 65535 and %0d; one receiver hold-off of %0d cycles.",
               middle_limit, LONG_HOLD);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
